// File: hdl/xoshiro128ss_random_source_assert.svh
// Assertion macros used by the xoshiro128** random source back part.
// Depends on nothing; files that assert include it by name.
`ifndef XOSHIRO128SS_RANDOM_SOURCE_ASSERT_SVH
`define XOSHIRO128SS_RANDOM_SOURCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XSRS_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("xsrs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define XSRS_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("xsrs assertion failed");

`endif

// File: hdl/xsrs_pkg.sv
// Types and constants of the xoshiro128** random source.
// Depends on nothing; used by the front, queue, back and top level.
package xsrs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned GEN_N    = 4;
    localparam int unsigned GEN_IDX_W = 2;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [WORD_W-1:0] SM_GOLDEN = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] SM_MUL_A  = 32'h85EB_CA6B;
    localparam logic [WORD_W-1:0] SM_MUL_B  = 32'hC2B2_AE35;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_FIXED,
        OP_RANGE,
        OP_FULL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] span;
    } entry_t;

    typedef enum logic [1:0] {
        SEED_IDLE,
        SEED_MIX_A,
        SEED_MIX_B
    } seed_state_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_DONE
    } back_state_t;

endpackage

// File: hdl/xsrs_front.sv
// Front part: generator state, SplitMix32 seeding and request classification.
// Depends on xsrs_pkg; pushes classified requests into xsrs_queue.
module xsrs_front
    import xsrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_kind,
    input  logic [WORD_W-1:0] in_low,
    input  logic [WORD_W-1:0] in_high,
    input  logic              q_full,
    output logic              q_push,
    output entry_t            q_entry
);

    seed_state_t          seed_state_reg, seed_state_next;
    logic [WORD_W-1:0]    acc_reg, acc_next;
    logic [GEN_IDX_W-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0]    mix_reg;
    logic [WORD_W-1:0]    gen_reg [GEN_N];

    logic [WORD_W-1:0] acc_add, mix_a, mix_b_prod, mix_out;
    logic              seed_write;
    logic [WORD_W-1:0] w1x5, w1rot, draw_out;
    logic [WORD_W-1:0] n0, n1, n2, n3, n2a, n3a;
    logic              inverted, advance;
    logic [WORD_W-1:0] span;

    assign acc_add    = acc_reg + SM_GOLDEN;
    assign mix_a      = (acc_add ^ (acc_add >> 16)) * SM_MUL_A;
    assign mix_b_prod = (mix_reg ^ (mix_reg >> 13)) * SM_MUL_B;
    assign mix_out    = mix_b_prod ^ (mix_b_prod >> 16);

    always_comb
    begin
        seed_state_next = seed_state_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        seed_write      = 1'b0;
        cfg_ready       = 1'b0;
        case (seed_state_reg)
            SEED_IDLE:
            begin
                cfg_ready = 1'b1;
                if (cfg_valid)
                begin
                    acc_next        = cfg_data;
                    idx_next        = '0;
                    seed_state_next = SEED_MIX_A;
                end
            end
            SEED_MIX_A:
            begin
                acc_next        = acc_add;
                seed_state_next = SEED_MIX_B;
            end
            SEED_MIX_B:
            begin
                seed_write = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == GEN_IDX_W'(GEN_N - 1))
                begin
                    seed_state_next = SEED_IDLE;
                end
                else
                begin
                    seed_state_next = SEED_MIX_A;
                end
            end
            default:
            begin
                seed_state_next = SEED_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_state_reg <= SEED_MIX_A;
            acc_reg        <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            seed_state_reg <= seed_state_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_a;
    end

    assign w1x5     = gen_reg[1] + (gen_reg[1] << 2);
    assign w1rot    = {w1x5[WORD_W-8:0], w1x5[WORD_W-1:WORD_W-7]};
    assign draw_out = w1rot + (w1rot << 3);

    assign n2  = gen_reg[2] ^ gen_reg[0];
    assign n3  = gen_reg[3] ^ gen_reg[1];
    assign n1  = gen_reg[1] ^ n2;
    assign n0  = gen_reg[0] ^ n3;
    assign n2a = n2 ^ (gen_reg[1] << 9);
    assign n3a = {n3[WORD_W-12:0], n3[WORD_W-1:WORD_W-11]};

    assign inverted = $signed(in_low) >= $signed(in_high);
    assign span     = in_high - in_low + 1'b1;

    assign in_ready = (seed_state_reg == SEED_IDLE) && !q_full;
    assign q_push   = in_valid && in_ready;
    assign advance  = q_push && !(in_kind && inverted);

    always_comb
    begin
        q_entry.word = draw_out;
        q_entry.low  = in_low;
        q_entry.span = span;
        if (!in_kind)
        begin
            q_entry.op = OP_WORD;
        end
        else if (inverted)
        begin
            q_entry.op = OP_FIXED;
        end
        else if (span == '0)
        begin
            q_entry.op = OP_FULL;
        end
        else
        begin
            q_entry.op = OP_RANGE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seed_write)
        begin
            gen_reg[idx_reg] <= mix_out;
        end
        else if (advance)
        begin
            gen_reg[0] <= n0;
            gen_reg[1] <= n1;
            gen_reg[2] <= n2a;
            gen_reg[3] <= n3a;
        end
    end

endmodule

// File: hdl/xsrs_queue.sv
// Short queue of classified requests between the front and back parts.
// Depends on xsrs_pkg for the entry type.
module xsrs_queue
    import xsrs_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full  = count_reg == (PTR_W+1)'(DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/xsrs_back.sv
// Back part: bit-serial remainder unit and the registered result word.
// Depends on xsrs_pkg and the assertion macros header.
`include "xoshiro128ss_random_source_assert.svh"
module xsrs_back
    import xsrs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  entry_t                    q_head,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [WORD_W-1:0]         out_word,
    output logic [FRAC_W-1:0]         out_fraction,
    output logic [WORD_W-1:0]         out_ranged
);

    back_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [WORD_W-1:0]    ranged_reg, ranged_next;
    logic [WORD_W-1:0]    hold_word_reg, hold_word_next;
    logic [WORD_W-1:0]    low_reg, low_next;
    logic [WORD_W-1:0]    span_reg, span_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;

    logic              out_free, load;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   trial_sub;

    assign out_free  = !out_valid_reg || out_ready;
    assign trial     = {rem_reg, quo_reg[WORD_W-1]};
    assign trial_sub = trial - {1'b0, span_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        word_next      = word_reg;
        ranged_next    = ranged_reg;
        hold_word_next = hold_word_reg;
        low_next       = low_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        q_pop          = 1'b0;
        load           = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        OP_WORD:
                        begin
                            load        = 1'b1;
                            word_next   = q_head.word;
                            ranged_next = '0;
                        end
                        OP_FIXED:
                        begin
                            load        = 1'b1;
                            word_next   = '0;
                            ranged_next = q_head.low;
                        end
                        OP_FULL:
                        begin
                            load        = 1'b1;
                            word_next   = q_head.word;
                            ranged_next = q_head.low + q_head.word;
                        end
                        default:
                        begin
                            hold_word_next = q_head.word;
                            low_next       = q_head.low;
                            span_next      = q_head.span;
                            rem_next       = '0;
                            quo_next       = q_head.word;
                            cnt_next       = DIV_CNT_W'(DIV_STEPS - 1);
                            state_next     = BACK_DIV;
                        end
                    endcase
                end
            end
            BACK_DIV:
            begin
                if (trial_sub[WORD_W])
                begin
                    rem_next = trial[WORD_W-1:0];
                end
                else
                begin
                    rem_next = trial_sub[WORD_W-1:0];
                end
                quo_next = quo_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = BACK_DONE;
                end
            end
            BACK_DONE:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    word_next   = hold_word_reg;
                    ranged_next = low_reg + rem_reg;
                    state_next  = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        ranged_reg    <= ranged_next;
        hold_word_reg <= hold_word_next;
        low_reg       <= low_next;
        span_reg      <= span_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_word     = word_reg;
    assign out_fraction = word_reg[WORD_W-1:WORD_W-FRAC_W];
    assign out_ranged   = ranged_reg;

    `XSRS_ASSERT_IMP(a_no_pop_while_dividing, clk, rst_n, state_reg != BACK_IDLE, !q_pop)
    `XSRS_ASSERT_NXT(a_div_ends_in_done, clk, rst_n,
        (state_reg == BACK_DIV) && (cnt_reg == '0), state_reg == BACK_DONE)
    `XSRS_ASSERT_IMP(a_rem_below_span, clk, rst_n,
        (state_reg == BACK_DIV) || (state_reg == BACK_DONE), rem_reg < span_reg)

endmodule

// File: hdl/xoshiro128ss_random_source.sv
// Top level of the xoshiro128** random source with SplitMix32 seeding.
// Depends on xsrs_pkg, xsrs_front, xsrs_queue and xsrs_back.
//
// Channel   Direction  Contents
// s_axis    in         tdata: range_low, range_high; tuser: kind
// m_axis    out        tdata: word, fraction, ranged_value
// cfg       in         data: seed
//
// A word draw, an inverted range and a full-width range pass from the queue straight
// into the back part's result registers. A range draw runs through the back part's
// one-bit-a-cycle remainder loop and then adds range_low before its word goes out.
// After reset and after each seed write, a SplitMix32 pass reloads the generator
// while s_axis_tready is low. A queue of QUEUE_DEPTH entries lets the front keep
// accepting while the back divides or m_axis is stalled.
module xoshiro128ss_random_source
    import xsrs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // range_low [31:0], range_high [63:32]
    input  logic [0:0]  s_axis_tuser,   // kind [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // word [31:0], fraction [55:32], ranged_value [87:56]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic              q_full, q_push, q_pop, q_valid;
    entry_t            push_entry, head;
    logic [WORD_W-1:0] out_word, out_ranged;
    logic [FRAC_W-1:0] out_fraction;

    xsrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser[0]),
        .in_low    (s_axis_tdata[31:0]),
        .in_high   (s_axis_tdata[63:32]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    xsrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (head)
    );

    xsrs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (head),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_word     (out_word),
        .out_fraction (out_fraction),
        .out_ranged   (out_ranged)
    );

    assign m_axis_tdata = {out_ranged, out_fraction, out_word};

endmodule

// File: tb/sv/tb_xoshiro128ss_random_source.sv
`timescale 1ns / 1ps
// Testbench for the xoshiro128** random source with SplitMix32 seeding.
// Depends on xoshiro128ss_random_source; predicts every word on its own.
module tb_xoshiro128ss_random_source;

    localparam logic [31:0] GOLDEN_STEP  = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MUL_A    = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_MUL_B    = 32'hC2B2_AE35;
    localparam int          SETTLE_LEN   = 48;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          REPORT_LIMIT = 100;

    typedef enum logic {
        DRAW_WORD  = 1'b0,
        DRAW_RANGE = 1'b1
    } draw_kind_t;

    typedef struct packed {
        logic [31:0] word;
        logic [23:0] fraction;
        logic [31:0] ranged_value;
    } draw_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // range_low [31:0], range_high [63:32]
    logic [0:0]  s_axis_tuser;   // kind [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // word [31:0], fraction [55:32], ranged_value [87:56]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    logic [31:0]  gen_words [4];
    draw_result_t pending_draws [$];
    draw_result_t oldest_draw;
    int           mismatch_count;
    int           bad_words;
    int           idle_cycles;
    int           rx_hold_request;
    bit           rx_steady;
    bit           tx_steady;

    xoshiro128ss_random_source i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reseed_generator(input logic [31:0] seed_value);
        logic [31:0] acc;
        logic [31:0] z;
        acc = seed_value;
        for (int i = 0; i < 4; i++)
        begin
            acc = acc + GOLDEN_STEP;
            z = acc;
            z = (z ^ (z >> 16)) * MIX_MUL_A;
            z = (z ^ (z >> 13)) * MIX_MUL_B;
            gen_words[i] = z ^ (z >> 16);
        end
    endfunction

    function automatic logic [31:0] advance_generator();
        logic [31:0] scaled;
        logic [31:0] scrambled;
        logic [31:0] shifted;
        scaled    = gen_words[1] * 32'd5;
        scrambled = {scaled[24:0], scaled[31:25]} * 32'd9;
        shifted   = gen_words[1] << 9;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ shifted;
        gen_words[3] = {gen_words[3][20:0], gen_words[3][31:21]};
        return scrambled;
    endfunction

    function automatic draw_result_t predict_draw(input draw_kind_t kind,
                                                  input logic [31:0] low,
                                                  input logic [31:0] high);
        draw_result_t result;
        logic [31:0]  span;
        result = '0;
        if (kind == DRAW_WORD)
        begin
            result.word = advance_generator();
        end
        else if ($signed(low) >= $signed(high))
        begin
            result.ranged_value = low;
        end
        else
        begin
            span = high - low + 32'd1;
            result.word = advance_generator();
            if (span == 32'd0)
                result.ranged_value = low + result.word;
            else
                result.ranged_value = low + (result.word % span);
        end
        result.fraction = result.word[31:8];
        return result;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input draw_kind_t kind, input logic [31:0] low,
                                input logic [31:0] high);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {high, low};
        s_axis_tuser  = kind;
        do @(posedge clk); while (!s_axis_tready);
        pending_draws.push_back(predict_draw(kind, low, high));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_draws.size() != 0) @(posedge clk);
        repeat (SETTLE_LEN) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed_value);
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = seed_value;
        do @(posedge clk); while (!cfg_ready);
        reseed_generator(seed_value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_request();
        draw_kind_t  kind;
        logic [31:0] low;
        logic [31:0] high;
        int          roll;
        kind = ($urandom_range(0, 99) < 40) ? DRAW_WORD : DRAW_RANGE;
        low  = $urandom();
        high = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 50)
            high = low + $urandom_range(0, 300);
        else if (roll < 60)
        begin
            low  = 32'h8000_0000;
            high = 32'h7FFF_FFFF;
        end
        else if (roll < 75)
            high = low - $urandom_range(0, 1000);
        send_request(kind, low, high);
    endtask

    task automatic test_directed();
        send_request(DRAW_WORD, 32'h0000_0000, 32'h0000_0000);
        send_request(DRAW_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(DRAW_WORD, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(DRAW_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(DRAW_RANGE, 32'h0000_0000, 32'h0000_0000);
        send_request(DRAW_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(DRAW_RANGE, 32'h8000_0000, 32'h8000_0000);
        send_request(DRAW_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(DRAW_RANGE, 32'h0000_0005, 32'hFFFF_FFFB);
        send_request(DRAW_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(DRAW_RANGE, 32'h0000_0000, 32'h0000_0001);
        send_request(DRAW_RANGE, 32'h8000_0000, 32'h8000_0001);
        send_request(DRAW_RANGE, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
        send_request(DRAW_RANGE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(DRAW_RANGE, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(DRAW_RANGE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(DRAW_RANGE, 32'h8000_0001, 32'h7FFF_FFFF);
        send_request(DRAW_RANGE, 32'h8000_0000, 32'h7FFF_FFFE);
        send_request(DRAW_RANGE, 32'hFFFF_FC18, 32'h0000_03E8);
        send_request(DRAW_RANGE, 32'h0000_0000, 32'h0000_0002);
        send_request(DRAW_WORD, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(DRAW_WORD, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    task automatic test_seed_extremes();
        logic [31:0] seeds [5];
        seeds = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000};
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            repeat (4) send_request(DRAW_WORD, $urandom(), $urandom());
            send_request(DRAW_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
            send_request(DRAW_RANGE, 32'hFFFF_FF00, 32'h0000_00FF);
        end
    endtask

    task automatic test_backpressure();
        tx_steady = 1'b1;
        rx_hold_request = 300;
        repeat (12) send_request(DRAW_WORD, $urandom(), $urandom());
        repeat (4) send_request(DRAW_RANGE, 32'h0000_0000, 32'h0000_0063);
        tx_steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (6) send_random_request();
        wait_idle();
        repeat (6) send_random_request();
    endtask

    task automatic test_random_draws();
        for (int chunk = 0; chunk < 10; chunk++)
        begin
            if (chunk % 3 == 2)
                write_seed($urandom());
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat (100) send_random_request();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin : drive_ready
            int gap;
            int hold;
            gap  = 0;
            hold = 0;
            forever
            begin
                @(negedge clk);
                if (rx_hold_request > 0)
                begin
                    hold = rx_hold_request;
                    rx_hold_request = 0;
                end
                if (hold > 0)
                begin
                    m_axis_tready = 1'b0;
                    hold--;
                end
                else if (rx_steady)
                    m_axis_tready = 1'b1;
                else if (gap > 0)
                begin
                    m_axis_tready = 1'b0;
                    gap--;
                end
                else
                begin
                    m_axis_tready = 1'b1;
                    gap = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("unexpected word out: %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                oldest_draw = pending_draws.pop_front();
                if (m_axis_tdata[31:0] !== oldest_draw.word
                    || m_axis_tdata[55:32] !== oldest_draw.fraction
                    || m_axis_tdata[87:56] !== oldest_draw.ranged_value)
                begin
                    mismatch_count++;
                    bad_words++;
                end
                if (bad_words <= REPORT_LIMIT)
                begin
                    if (m_axis_tdata[31:0] !== oldest_draw.word)
                        $error("word: expected %h, got %h",
                               oldest_draw.word, m_axis_tdata[31:0]);
                    if (m_axis_tdata[55:32] !== oldest_draw.fraction)
                        $error("fraction: expected %h, got %h",
                               oldest_draw.fraction, m_axis_tdata[55:32]);
                    if (m_axis_tdata[87:56] !== oldest_draw.ranged_value)
                        $error("ranged_value: expected %h, got %h",
                               oldest_draw.ranged_value, m_axis_tdata[87:56]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n
            || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        mismatch_count  = 0;
        bad_words       = 0;
        idle_cycles     = 0;
        rx_hold_request = 0;
        rx_steady       = 1'b0;
        tx_steady       = 1'b0;
        reseed_generator(32'h0000_0000);
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_seed_extremes();
        test_backpressure();
        test_drain_pause();
        test_random_draws();
        wait_idle();

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/xsrs_pkg.sv
hdl/xsrs_front.sv
hdl/xsrs_queue.sv
hdl/xsrs_back.sv
hdl/xoshiro128ss_random_source.sv
tb/sv/tb_xoshiro128ss_random_source.sv
